@@ hdl/rhc_pkg.sv @@
// Shared types and constants for the RGB/HSL color converter.
`default_nettype none

package rhc_pkg;

  localparam int CHANNEL_BITS = 12;
  localparam int CW = CHANNEL_BITS;

  // full scale: all ones means 1.0
  localparam logic [CW-1:0] CH_MAX = {CW{1'b1}};

  // request codes; the spare code is handled as a lightness shift
  localparam logic [1:0] REQ_TO_HSL = 2'd0;
  localparam logic [1:0] REQ_TO_RGB = 2'd1;
  localparam logic [1:0] REQ_SHIFT  = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  // divider widths: dividend below 2^(2C+3), divisor below 2^(C+3)
  localparam int DIV_DW = 2 * CW + 3;
  localparam int DIV_VW = CW + 3;

  typedef logic [CW-1:0]      ch_t;
  typedef logic signed [CW:0] delta_t;

  typedef struct packed {
    logic [1:0] req;
    ch_t        a;
    ch_t        b;
    ch_t        c;
    ch_t        alpha;
    delta_t     delta;
  } pix_t;

  typedef struct packed {
    pix_t pix;
    ch_t  h;
    ch_t  s;
    ch_t  l;
  } hsl_t;

  typedef struct packed {
    ch_t x;
    ch_t y;
    ch_t z;
    ch_t alpha;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/rgb_hsl_color_converter.sv @@
// Top level of the RGB/HSL color converter.
//
//  channel | words                                   | handshake
//  --------+-----------------------------------------+--------------------
//  input   | req_type comp_a comp_b comp_c alpha_in   | in_valid / in_stall
//          | delta                                   |
//  output  | out_a out_b out_c alpha_out             | out_valid / out_stall
//
// One word per clock in and out while neither side stalls. RGB->HSL
// takes min/max, divider setup and one quotient bit per stage for 12
// bits of saturation and hue in parallel; HSL->RGB takes select/shift,
// multiply, q numerator, divide by full scale, p, ramp multiply, output.
// Every request type takes the same path, so words leave in order.
// rst is synchronous and clears only the per-stage valid bits.
// A stall fills bubbles first: a stage holds only when it and every stage
// after it are full, so out_stall reaches in_stall only with all full.
`default_nettype none

module rgb_hsl_color_converter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  rhc_pkg::ch_t         comp_a,
  input  rhc_pkg::ch_t         comp_b,
  input  rhc_pkg::ch_t         comp_c,
  input  rhc_pkg::ch_t         alpha_in,
  input  rhc_pkg::delta_t      delta,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rhc_pkg::ch_t         out_a,
  output rhc_pkg::ch_t         out_b,
  output rhc_pkg::ch_t         out_c,
  output rhc_pkg::ch_t         alpha_out
);
  import rhc_pkg::*;

  pix_t pix;
  hsl_t mid;
  res_t res;
  logic mid_valid;
  logic mid_stall;

  assign pix.req   = req_type;
  assign pix.a     = comp_a;
  assign pix.b     = comp_b;
  assign pix.c     = comp_c;
  assign pix.alpha = alpha_in;
  assign pix.delta = delta;

  // front half: RGB to HSL; plain HSL->RGB words ride along untouched
  rhc_hsl u_hsl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pix    (pix),
    .out_valid (mid_valid),
    .out_stall (mid_stall),
    .out_hsl   (mid)
  );

  // back half: picks the source of H/S/L per request, then HSL to RGB
  rhc_rgb u_rgb (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_valid),
    .in_stall  (mid_stall),
    .in_hsl    (mid),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  assign out_a     = res.x;
  assign out_b     = res.y;
  assign out_c     = res.z;
  assign alpha_out = res.alpha;

endmodule

`default_nettype wire

@@ hdl/rhc_hsl.sv @@
// RGB to HSL pipeline: min/max, setup, then one quotient bit per stage.
`default_nettype none

module rhc_hsl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rhc_pkg::pix_t in_pix,
  output logic          out_valid,
  input  logic          out_stall,
  output rhc_pkg::hsl_t out_hsl
);
  import rhc_pkg::*;

  localparam int NS = CW + 2;
  localparam int NW = CW + 4;

  typedef enum logic [1:0] {SX_RED, SX_GREEN, SX_BLUE} sext_t;

  typedef struct packed {
    pix_t  pix;
    ch_t   mx;
    ch_t   mn;
    sext_t sext;
    logic  gray;
  } mm_t;

  typedef struct packed {
    pix_t              pix;
    logic              gray;
    ch_t               l;
    logic [DIV_DW-1:0] s_rem;
    logic [DIV_DW-1:0] h_rem;
    logic [DIV_VW-1:0] s_den;
    logic [DIV_VW-1:0] h_den;
    ch_t               s_q;
    ch_t               h_q;
  } dv_t;

  logic [NS-1:0] v;
  logic [NS-1:0] hold;

  mm_t mm, mm_next;
  dv_t dv      [CW+1];
  dv_t dv_next [CW+1];

  logic [CW-1:0]        d;
  logic [CW:0]          sum;
  logic signed [NW-1:0] de, ra, ga, ba, num;

  // a stage holds when it is full and the one after it holds
  always_comb begin
    hold[NS-1] = v[NS-1] & out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      hold[k] = v[k] & hold[k+1];
    end
  end

  assign in_stall = hold[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (!hold[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (!hold[k]) v[k] <= v[k-1];
      end
    end
  end

  // max, min and hue sextant (red wins ties, then green)
  always_comb begin
    mm_next.pix  = in_pix;
    mm_next.mx   = in_pix.a;
    if (in_pix.b > mm_next.mx) mm_next.mx = in_pix.b;
    if (in_pix.c > mm_next.mx) mm_next.mx = in_pix.c;
    mm_next.mn   = in_pix.a;
    if (in_pix.b < mm_next.mn) mm_next.mn = in_pix.b;
    if (in_pix.c < mm_next.mn) mm_next.mn = in_pix.c;
    if (in_pix.a == mm_next.mx)      mm_next.sext = SX_RED;
    else if (in_pix.b == mm_next.mx) mm_next.sext = SX_GREEN;
    else                             mm_next.sext = SX_BLUE;
    mm_next.gray = (in_pix.a == in_pix.b) && (in_pix.b == in_pix.c);
  end

  // divider setup: saturation d*M / den, hue (num << C) / 6d
  always_comb begin
    d   = mm.mx - mm.mn;
    sum = {1'b0, mm.mx} + {1'b0, mm.mn};
    de  = NW'(d);
    ra  = NW'(mm.pix.a);
    ga  = NW'(mm.pix.b);
    ba  = NW'(mm.pix.c);
    case (mm.sext)
      SX_RED:   num = ga - ba;
      SX_GREEN: num = (de <<< 1) + ba - ra;
      default:  num = (de <<< 2) + ra - ga;
    endcase
    if (num < 0) num = num + (de <<< 2) + (de <<< 1);

    dv_next[0].pix   = mm.pix;
    dv_next[0].gray  = mm.gray;
    dv_next[0].l     = sum[CW:1];
    dv_next[0].s_rem = (DIV_DW'(d) << CW) - DIV_DW'(d);
    dv_next[0].s_den = (sum < {1'b0, CH_MAX}) ? DIV_VW'(sum)
                     : DIV_VW'({CH_MAX, 1'b0}) - DIV_VW'(sum);
    dv_next[0].h_rem = DIV_DW'(unsigned'(num)) << CW;
    dv_next[0].h_den = (DIV_VW'(d) << 2) + (DIV_VW'(d) << 1);
    dv_next[0].s_q   = '0;
    dv_next[0].h_q   = '0;
  end

  // restoring division, MSB first; both quotients fit in C bits
  for (genvar k = 1; k <= CW; k++) begin : g_div
    localparam int BIT = CW - k;
    logic [DIV_DW-1:0] s_sh, h_sh;
    always_comb begin
      s_sh = DIV_DW'(dv[k-1].s_den) << BIT;
      h_sh = DIV_DW'(dv[k-1].h_den) << BIT;
      dv_next[k] = dv[k-1];
      if (dv[k-1].s_rem >= s_sh) begin
        dv_next[k].s_rem    = dv[k-1].s_rem - s_sh;
        dv_next[k].s_q[BIT] = 1'b1;
      end
      if (dv[k-1].h_rem >= h_sh) begin
        dv_next[k].h_rem    = dv[k-1].h_rem - h_sh;
        dv_next[k].h_q[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!hold[0]) mm <= mm_next;
    for (int k = 0; k <= CW; k++) begin
      if (!hold[k+1]) dv[k] <= dv_next[k];
    end
  end

  // gray: hue and saturation zero, lightness equals the channel
  assign out_valid   = v[NS-1];
  assign out_hsl.pix = dv[CW].pix;
  assign out_hsl.h   = dv[CW].gray ? '0 : dv[CW].h_q;
  assign out_hsl.s   = dv[CW].gray ? '0 : dv[CW].s_q;
  assign out_hsl.l   = dv[CW].l;

endmodule

`default_nettype wire

@@ hdl/rhc_rgb.sv @@
// HSL to RGB pipeline with request select and lightness shift at its head.
`default_nettype none

module rhc_rgb (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rhc_pkg::hsl_t in_hsl,
  output logic          out_valid,
  input  logic          out_stall,
  output rhc_pkg::res_t out_res
);
  import rhc_pkg::*;

  localparam int NS = 7;
  localparam int XW = 2 * CW + 1;
  localparam int HW = CW + 2;
  localparam logic [HW-1:0] HUE_THIRD = HW'(1) << CW;
  localparam logic [HW-1:0] HUE_FULL  = HW'(3 * HUE_THIRD);
  localparam logic [HW-1:0] HUE_HALF  = HUE_THIRD >> 1;

  typedef enum logic [1:0] {RG_RISE, RG_HIGH, RG_FALL, RG_LOW} region_t;

  typedef struct packed {
    logic bypass;
    ch_t  alpha;
    ch_t  h;
    ch_t  s;
    ch_t  l;
  } base_t;

  typedef struct packed {
    base_t             bs;
    logic              lt2;
    logic [2*CW-1:0]   ls;
    logic [2:0][HW-1:0] t;
  } st1_t;

  typedef struct packed {
    base_t              bs;
    logic [2*CW-1:0]    x;
    logic [2:0][HW-1:0] t;
  } st2_t;

  typedef struct packed {
    base_t              bs;
    ch_t                q;
    logic [2:0][HW-1:0] t;
  } st3_t;

  typedef struct packed {
    base_t              bs;
    ch_t                q;
    ch_t                p;
    region_t [2:0]      rg;
    logic [2:0][CW-1:0] f;
  } st4_t;

  typedef struct packed {
    base_t                bs;
    ch_t                  q;
    ch_t                  p;
    region_t [2:0]        rg;
    logic [2:0][2*CW-1:0] prod;
  } st5_t;

  logic [NS-1:0] v;
  logic [NS-1:0] hold;

  base_t st0, st0_next;
  st1_t  st1, st1_next;
  st2_t  st2, st2_next;
  st3_t  st3, st3_next;
  st4_t  st4, st4_next;
  st5_t  st5, st5_next;
  res_t  st6, st6_next;

  logic signed [CW+1:0] lsum;
  logic [HW-1:0]        h3;
  logic [XW-1:0]        lm, sm, xs;
  logic [CW:0]          rr;
  logic signed [CW+1:0] pd;
  logic [2:0][CW:0]     lin;
  ch_t  [2:0]           chv;

  always_comb begin
    hold[NS-1] = v[NS-1] & out_stall;
    for (int k = NS - 2; k >= 0; k--) begin
      hold[k] = v[k] & hold[k+1];
    end
  end

  assign in_stall = hold[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (!hold[0]) v[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (!hold[k]) v[k] <= v[k-1];
      end
    end
  end

  // request select; shift clamps L + delta to 0..M
  always_comb begin
    lsum = signed'({1'b0, in_hsl.l}) + in_hsl.pix.delta;
    st0_next.alpha = in_hsl.pix.alpha;
    st0_next.h     = in_hsl.h;
    st0_next.s     = in_hsl.s;
    st0_next.l     = in_hsl.l;
    case (in_hsl.pix.req)
      REQ_TO_HSL: begin
        st0_next.bypass = 1'b1;
      end
      REQ_TO_RGB: begin
        st0_next.bypass = 1'b0;
        st0_next.h      = in_hsl.pix.a;
        st0_next.s      = in_hsl.pix.b;
        st0_next.l      = in_hsl.pix.c;
      end
      default: begin
        st0_next.bypass = 1'b0;
        if (lsum[CW+1])  st0_next.l = '0;
        else if (lsum[CW]) st0_next.l = CH_MAX;
        else             st0_next.l = lsum[CW-1:0];
      end
    endcase
  end

  // L*S product and hue offsets per channel (third of a turn = 2^C)
  always_comb begin
    h3 = (HW'(st0.h) << 1) + HW'(st0.h);
    st1_next.bs   = st0;
    st1_next.lt2  = {st0.l, 1'b0} < {1'b0, CH_MAX};
    st1_next.ls   = st0.l * st0.s;
    st1_next.t[1] = h3;
    st1_next.t[0] = h3 + HUE_THIRD;
    if (st1_next.t[0] >= HUE_FULL) st1_next.t[0] = st1_next.t[0] - HUE_FULL;
    st1_next.t[2] = (h3 >= HUE_THIRD) ? h3 - HUE_THIRD : h3 + HUE_FULL - HUE_THIRD;
  end

  // numerator of q
  always_comb begin
    lm = (XW'(st1.bs.l) << CW) - XW'(st1.bs.l);
    sm = (XW'(st1.bs.s) << CW) - XW'(st1.bs.s);
    if (st1.lt2) xs = lm + XW'(st1.ls);
    else         xs = lm + sm - XW'(st1.ls);
    st2_next.bs = st1.bs;
    st2_next.x  = xs[2*CW-1:0];
    st2_next.t  = st1.t;
  end

  // q = x / M: x>>C plus one correction
  always_comb begin
    rr = {1'b0, st2.x[CW-1:0]} + {1'b0, st2.x[2*CW-1:CW]};
    st3_next.bs = st2.bs;
    st3_next.q  = st2.x[2*CW-1:CW] + CW'(rr >= {1'b0, CH_MAX});
    st3_next.t  = st2.t;
  end

  // p = 2L - q floored at zero; ramp region and fraction per channel
  always_comb begin
    pd = signed'({1'b0, st3.bs.l, 1'b0}) - signed'({2'b0, st3.q});
    st4_next.bs = st3.bs;
    st4_next.q  = st3.q;
    st4_next.p  = pd[CW+1] ? '0 : pd[CW-1:0];
    for (int c = 0; c < 3; c++) begin
      if (st3.t[c] < HUE_HALF) begin
        st4_next.rg[c] = RG_RISE;
        st4_next.f[c]  = st3.t[c][CW-1:0];
      end else if (st3.t[c] < HW'(3 * HUE_HALF)) begin
        st4_next.rg[c] = RG_HIGH;
        st4_next.f[c]  = '0;
      end else if (st3.t[c] < HW'(4 * HUE_HALF)) begin
        st4_next.rg[c] = RG_FALL;
        st4_next.f[c]  = CW'(HW'(4 * HUE_HALF) - st3.t[c]);
      end else begin
        st4_next.rg[c] = RG_LOW;
        st4_next.f[c]  = '0;
      end
    end
  end

  always_comb begin
    st5_next.bs = st4.bs;
    st5_next.q  = st4.q;
    st5_next.p  = st4.p;
    st5_next.rg = st4.rg;
    for (int c = 0; c < 3; c++) begin
      st5_next.prod[c] = (st4.q - st4.p) * st4.f[c];
    end
  end

  // channel values, then bypass for plain RGB->HSL and zero saturation
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lin[c] = {1'b0, st5.p} + st5.prod[c][2*CW-1:CW-1];
      case (st5.rg[c])
        RG_RISE, RG_FALL: chv[c] = lin[c][CW] ? CH_MAX : lin[c][CW-1:0];
        RG_HIGH:          chv[c] = st5.q;
        default:          chv[c] = st5.p;
      endcase
    end
    st6_next.alpha = st5.bs.alpha;
    if (st5.bs.bypass) begin
      st6_next.x = st5.bs.h;
      st6_next.y = st5.bs.s;
      st6_next.z = st5.bs.l;
    end else if (st5.bs.s == '0) begin
      st6_next.x = st5.bs.l;
      st6_next.y = st5.bs.l;
      st6_next.z = st5.bs.l;
    end else begin
      st6_next.x = chv[0];
      st6_next.y = chv[1];
      st6_next.z = chv[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!hold[0]) st0 <= st0_next;
    if (!hold[1]) st1 <= st1_next;
    if (!hold[2]) st2 <= st2_next;
    if (!hold[3]) st3 <= st3_next;
    if (!hold[4]) st4 <= st4_next;
    if (!hold[5]) st5 <= st5_next;
    if (!hold[6]) st6 <= st6_next;
  end

  assign out_valid = v[NS-1];
  assign out_res   = st6;

endmodule

`default_nettype wire

@@ hdl/rhc_check.sv @@
// Port-level checks for the color converter, bound to the top level.
`default_nettype none

module rhc_check (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input rhc_pkg::ch_t         out_a,
  input rhc_pkg::ch_t         out_b,
  input rhc_pkg::ch_t         out_c,
  input rhc_pkg::ch_t         alpha_out
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // input backs up only when the whole pipe is full and the output stalls
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipe");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      ($stable(out_a) && $stable(out_b) && $stable(out_c) && $stable(alpha_out)))
    else $error("output word changed while stalled");

endmodule

bind rgb_hsl_color_converter rhc_check u_rhc_check (.*);

`default_nettype wire
